>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is asserted.
`define BPSQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bpsq assertion failed");
// Assertion that is checked at every edge, also during reset.
`define BPSQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bpsq assertion failed");
`else
`define BPSQ_ASSERT(lbl, clk, rst_n, prop)
`define BPSQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/bpsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsq_pkg
// Types, constants and helper functions of the bitmap priority slot queue.
// ----------------------------------------------------------------------------
package bpsq_pkg;

  localparam int LEVELS    = 256;
  localparam int SLOTS     = 32;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = LEVELS / WORD_BITS;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WRD_W     = $clog2(NWORDS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 32;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_RELEASE   = 3'd2,
    CMD_SCOPE     = 3'd3,
    CMD_PRIO_NODE = 3'd4,
    CMD_NODE_PRIO = 3'd5,
    CMD_STATUS    = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT = 2'd2;

  // One result item.
  typedef struct packed {
    logic              is_empty;
    logic [SLOT_W-1:0] used_count;
    logic [SLOT_W-1:0] node_out;
    logic [LVL_W-1:0]  worst_prio;
    logic [LVL_W-1:0]  prio_out;
    logic              ok;
  } res_t;

  // Access requests toward the two memories.
  typedef struct packed {
    logic                 we;
    logic [WRD_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WRD_W-1:0]     raddr;
  } bmp_req_t;

  typedef struct packed {
    logic              we;
    logic [LVL_W-1:0]  waddr;
    logic [SLOT_W-1:0] wdata;
    logic [LVL_W-1:0]  raddr;
  } l2s_req_t;

  // Position of the lowest set bit of a bitmap word.
  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

  // Position of the highest set bit of a bitmap word.
  function automatic logic [BIT_W-1:0] last_one(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) pos = BIT_W'(i);
    end
    return pos;
  endfunction

endpackage

>>> design/bpsq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsq_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpsq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/bpsq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsq_ctrl
// Command sequencer: reads, modifies and writes back the bitmap and the
// level-to-slot map, and keeps the slot priority store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpsq_ctrl import bpsq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration writes.
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]     cfg_data_i,
  // Command input.
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  logic [2:0]               command_i,
  input  logic [LVL_W-1:0]         priority_req_i,
  input  logic [SLOT_W-1:0]        node_id_i,
  // Result toward the output register.
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output res_t                     res_o,
  // Memory ports.
  output bmp_req_t                 bmp_req_o,
  input  logic [WORD_BITS-1:0]     bmp_rdata_i,
  output l2s_req_t                 l2s_req_o,
  input  logic [SLOT_W-1:0]        l2s_rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_L2S  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PRIO = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]           state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [LVL_W-1:0]     lvl_q, lvl_d;
  logic [SLOT_W-1:0]    nid_q, nid_d;
  logic [WRD_W-1:0]     w_q, w_d;
  logic                 lowest_q, lowest_d;
  logic                 second_q, second_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 ok_q, ok_d;
  logic [LVL_W-1:0]     pout_q, pout_d;
  logic [LVL_W-1:0]     wout_q, wout_d;
  logic [SLOT_W-1:0]    nout_q, nout_d;

  logic [LVL_W-1:0]     max_prio_q;
  logic                 small_high_q;
  logic [SLOT_W-1:0]    node_limit_q;

  logic [SLOTS-1:0]     slot_free_q, slot_free_d;
  logic [SLOT_W-1:0]    count_q, count_d;
  logic [NWORDS-1:0]    bmp_vld_q, bmp_vld_d;
  logic                 bmp_vld_rd_q;

  // Slot priority store, one register per slot.
  logic [LVL_W-1:0]     slot_prio_q [SLOTS];
  logic                 prio_we;
  logic [SLOT_W-1:0]    prio_waddr;
  logic [LVL_W-1:0]     prio_wdata;
  logic                 prio_clr;
  logic [LVL_W-1:0]     clr_prio;

  bmp_req_t             bmp_req;
  l2s_req_t             l2s_req;

  logic [WORD_BITS-1:0] bmp_word;
  logic [WORD_BITS-1:0] scan_word;
  logic [WRD_W-1:0]     max_w;
  logic [BIT_W-1:0]     scan_pos;
  logic [LVL_W-1:0]     scan_lvl;
  logic [WRD_W-1:0]     end_w;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic                 cmd_acc;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign cmd_acc     = cmd_valid_i && cmd_ready_o;
  assign max_w       = max_prio_q[LVL_W-1:BIT_W];
  assign clr_prio    = small_high_q ? max_prio_q : '0;

  // A row that was never written since clear reads as all zero.
  assign bmp_word = bmp_vld_rd_q ? bmp_rdata_i : '0;

  // Only levels up to the maximum priority are visible to a scan.
  always_comb begin
    scan_word = bmp_word;
    if (w_q == max_w) begin
      scan_word = bmp_word & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - max_prio_q[BIT_W-1:0]));
    end
  end

  assign scan_pos = lowest_q ? first_one(scan_word) : last_one(scan_word);
  assign scan_lvl = {w_q, scan_pos};
  assign end_w    = lowest_q ? max_w : '0;

  // Lowest free slot below the node limit.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_free_q[i] && (SLOT_W'(i) < node_limit_q)) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Command sequencer.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    lvl_d      = lvl_q;
    nid_d      = nid_q;
    w_d        = w_q;
    lowest_d   = lowest_q;
    second_d   = second_q;
    word_d     = word_q;
    ok_d       = ok_q;
    pout_d     = pout_q;
    wout_d     = wout_q;
    nout_d     = nout_q;
    slot_free_d = slot_free_q;
    count_d    = count_q;
    bmp_vld_d  = bmp_vld_q;
    prio_we    = 1'b0;
    prio_waddr = '0;
    prio_wdata = '0;
    prio_clr   = 1'b0;
    bmp_req    = '0;
    l2s_req    = '0;
    bmp_req.raddr  = lvl_q[LVL_W-1:BIT_W];
    l2s_req.raddr  = lvl_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          cmd_d    = cmd_e'(command_i);
          lvl_d    = priority_req_i;
          nid_d    = node_id_i;
          ok_d     = 1'b0;
          pout_d   = '0;
          wout_d   = '0;
          nout_d   = '0;
          second_d = 1'b0;
          lowest_d = small_high_q;
          bmp_req.raddr  = priority_req_i[LVL_W-1:BIT_W];
          state_d  = S_RESP;
          case (cmd_e'(command_i)) inside
            CMD_PUSH: begin
              if ((count_q < node_limit_q) && (priority_req_i <= max_prio_q)) begin
                state_d = S_CHK;
              end
            end
            CMD_RELEASE, CMD_NODE_PRIO: begin
              if (priority_req_i <= max_prio_q) begin
                state_d = S_CHK;
              end
            end
            CMD_POP, CMD_SCOPE: begin
              w_d           = small_high_q ? '0 : max_w;
              bmp_req.raddr = w_d;
              state_d       = S_SCAN;
            end
            CMD_PRIO_NODE: begin
              if (node_id_i < node_limit_q) begin
                state_d = S_PRIO;
              end
            end
            CMD_STATUS: begin
              ok_d = 1'b1;
            end
            default: begin
              // Clear: drop every entry and load the idle slot priority.
              ok_d        = 1'b1;
              bmp_vld_d   = '0;
              prio_clr    = 1'b1;
              slot_free_d = '1;
              count_d     = '0;
            end
          endcase
        end
      end

      S_CHK: begin
        word_d  = bmp_word;
        state_d = S_RESP;
        if (bmp_word[lvl_q[BIT_W-1:0]]) begin
          state_d = S_L2S;
        end else if (cmd_q == CMD_PUSH && free_found) begin
          // Allocate a new slot for this level.
          bmp_req.we     = 1'b1;
          bmp_req.waddr  = lvl_q[LVL_W-1:BIT_W];
          bmp_req.wdata  = bmp_word | (WORD_BITS'(1) << lvl_q[BIT_W-1:0]);
          bmp_vld_d[lvl_q[LVL_W-1:BIT_W]] = 1'b1;
          l2s_req.we     = 1'b1;
          l2s_req.waddr  = lvl_q;
          l2s_req.wdata  = free_idx;
          prio_we        = 1'b1;
          prio_waddr     = free_idx;
          prio_wdata     = lvl_q;
          slot_free_d[free_idx] = 1'b0;
          count_d = count_q + SLOT_W'(1);
          ok_d    = 1'b1;
          nout_d  = free_idx;
        end
      end

      S_L2S: begin
        ok_d    = 1'b1;
        nout_d  = l2s_rdata_i;
        state_d = S_RESP;
        if (cmd_q == CMD_POP || cmd_q == CMD_RELEASE) begin
          // Free the slot and clear the level bit.
          bmp_req.we    = 1'b1;
          bmp_req.waddr = lvl_q[LVL_W-1:BIT_W];
          bmp_req.wdata = word_q & ~(WORD_BITS'(1) << lvl_q[BIT_W-1:0]);
          bmp_vld_d[lvl_q[LVL_W-1:BIT_W]] = 1'b1;
          slot_free_d[l2s_rdata_i] = 1'b1;
          count_d = count_q - SLOT_W'(1);
          if (cmd_q == CMD_POP) begin
            pout_d = lvl_q;
          end
        end
      end

      S_SCAN: begin
        if (scan_word != '0) begin
          if (cmd_q == CMD_POP) begin
            lvl_d         = scan_lvl;
            word_d        = bmp_word;
            l2s_req.raddr = scan_lvl;
            state_d       = S_L2S;
          end else if (!second_q) begin
            // Best level found; scan again from the other end.
            pout_d        = scan_lvl;
            second_d      = 1'b1;
            lowest_d      = !lowest_q;
            w_d           = lowest_q ? max_w : '0;
            bmp_req.raddr = w_d;
          end else begin
            wout_d  = scan_lvl;
            ok_d    = 1'b1;
            state_d = S_RESP;
          end
        end else if (w_q == end_w) begin
          pout_d  = '0;
          state_d = S_RESP;
        end else begin
          w_d           = lowest_q ? w_q + WRD_W'(1) : w_q - WRD_W'(1);
          bmp_req.raddr = w_d;
        end
      end

      S_PRIO: begin
        ok_d    = 1'b1;
        pout_d  = slot_prio_q[nid_q];
        state_d = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign bmp_req_o  = bmp_req;
  assign l2s_req_o  = l2s_req;

  assign res_valid_o      = (state_q == S_RESP);
  assign res_o.ok         = ok_q;
  assign res_o.prio_out   = pout_q;
  assign res_o.worst_prio = wout_q;
  assign res_o.node_out   = nout_q;
  assign res_o.used_count = count_q;
  assign res_o.is_empty   = (count_q == '0);

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_prio_q   <= '1;
      small_high_q <= 1'b1;
      node_limit_q <= '1;
      slot_free_q  <= '1;
      count_q      <= '0;
      bmp_vld_q    <= '0;
    end else begin
      state_q     <= state_d;
      slot_free_q <= slot_free_d;
      count_q     <= count_d;
      bmp_vld_q   <= bmp_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_PRIO:   max_prio_q   <= cfg_data_i;
          CFG_SMALL_HIGH: small_high_q <= cfg_data_i[0];
          CFG_NODE_LIMIT: node_limit_q <= cfg_data_i[SLOT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Slot priority store: reset and clear load the idle priority.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_prio_q[i] <= '1;
      end
    end else if (prio_clr) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_prio_q[i] <= clr_prio;
      end
    end else if (prio_we) begin
      slot_prio_q[prio_waddr] <= prio_wdata;
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    lvl_q         <= lvl_d;
    nid_q         <= nid_d;
    w_q           <= w_d;
    lowest_q      <= lowest_d;
    second_q      <= second_d;
    word_q        <= word_d;
    ok_q          <= ok_d;
    pout_q        <= pout_d;
    wout_q        <= wout_d;
    nout_q        <= nout_d;
    bmp_vld_rd_q  <= bmp_vld_d[bmp_req.raddr] & bmp_vld_q[bmp_req.raddr];
  end

  // The use count always matches the number of allocated slots.
  `BPSQ_ASSERT(a_count_match, clk_i, rst_ni, count_q == SLOT_W'($countones(~slot_free_q)))
  // A command never changes the count by more than one, except clear.
  `BPSQ_ASSERT(a_count_step, clk_i, rst_ni, (count_q == $past(count_q)) || (count_q == $past(count_q) + SLOT_W'(1)) || (count_q == $past(count_q) - SLOT_W'(1)) || (count_q == '0))
  // An accepted command is always followed by work or a result.
  `BPSQ_ASSERT(a_acc_busy, clk_i, rst_ni, cmd_acc |=> (state_q != S_IDLE))
  // No memory write happens while waiting for a command.
  `BPSQ_ASSERT(a_idle_nowr, clk_i, rst_ni, (state_q == S_IDLE) |-> !(bmp_req.we || l2s_req.we || prio_we))

endmodule

>>> design/bitmap_priority_slot_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_priority_slot_queue
// Priority queue with one entry per level, a level bitmap and a slot pool.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata: command[2:0], priority_req[10:3], node_id[15:11]
// m_axis    out        tdata: ok, prio_out, worst_prio, node_out, used_count,
//                      is_empty, zero padding
// cfg       in         cfg_we_i, cfg_idx_i (0 max, 1 order, 2 limit), cfg_data_i
//
// One command is processed at a time; pop and scope scan the bitmap one
// word after another (up to 8 words, scope scans twice) through the single
// bitmap memory read port.
// Reset empties the queue at once; no clearing pass is needed.
// A new command is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_priority_slot_queue import bpsq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // command[2:0], priority_req[10:3], node_id[15:11]
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // ok[0], prio_out[8:1], worst_prio[16:9], node_out[21:17],
  // used_count[26:22], is_empty[27], zero[31:28]
  output logic [OUT_W-1:0]     m_axis_tdata
);

  res_t                 res;
  logic                 res_valid;
  logic                 res_ready;
  bmp_req_t             bmp_req;
  l2s_req_t             l2s_req;
  logic [WORD_BITS-1:0] bmp_rdata;
  logic [SLOT_W-1:0]    l2s_rdata;
  logic                 out_vld_q;
  res_t                 out_q;

  bpsq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_o    (s_axis_tready),
    .command_i      (s_axis_tdata[2:0]),
    .priority_req_i (s_axis_tdata[10:3]),
    .node_id_i      (s_axis_tdata[15:11]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .bmp_req_o      (bmp_req),
    .bmp_rdata_i    (bmp_rdata),
    .l2s_req_o      (l2s_req),
    .l2s_rdata_i    (l2s_rdata)
  );

  // Level bitmap, one word per row.
  bpsq_ram #(.DEPTH(NWORDS), .WIDTH(WORD_BITS)) u_bmp_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_req.we),
    .waddr_i (bmp_req.waddr),
    .wdata_i (bmp_req.wdata),
    .raddr_i (bmp_req.raddr),
    .rdata_o (bmp_rdata)
  );

  // Level-to-slot map.
  bpsq_ram #(.DEPTH(LEVELS), .WIDTH(SLOT_W)) u_l2s_ram (
    .clk_i   (clk_i),
    .we_i    (l2s_req.we),
    .waddr_i (l2s_req.waddr),
    .wdata_i (l2s_req.wdata),
    .raddr_i (l2s_req.raddr),
    .rdata_o (l2s_rdata)
  );

  // Output register decouples the result from the next command.
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, out_q};

endmodule

>>> bench/bitmap_priority_slot_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_priority_slot_queue_tb
// Self-checking bench for the bitmap priority slot queue. A directed table
// covers reset values, extremes and failure cases, then random command
// streams run under several register settings against a behavioral queue.
// Both stream sides idle at random, and once the output holds off for a
// long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module bitmap_priority_slot_queue_tb;
  import bpsq_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // command[2:0], priority_req[10:3], node_id[15:11]
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // ok[0], prio_out[8:1], worst_prio[16:9], node_out[21:17],
  // used_count[26:22], is_empty[27], zero[31:28]
  logic [OUT_W-1:0]     m_axis_tdata;

  bitmap_priority_slot_queue i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Behavioral copy of the queue state and the registers.
  logic [LEVELS-1:0] lvl_map;
  logic              slot_is_free [SLOTS];
  logic [LVL_W-1:0]  slot_level [SLOTS];
  logic [SLOT_W-1:0] level_slot [LEVELS];
  int unsigned       in_use;
  logic [7:0]        max_prio_q;
  logic              small_first_q;
  logic [4:0]        node_limit_q;

  res_t        pending_results[$];
  int unsigned n_errors;
  int unsigned n_checked;
  int unsigned n_sent;
  bit          hold_req;
  bit          out_busy;

  // Directed rows: typed expectation only where it is obvious.
  typedef struct {
    cmd_e              cmd;
    logic [LVL_W-1:0]  prio;
    logic [SLOT_W-1:0] node;
    bit                typed;
    res_t              want;
  } row_t;
  row_t rows[$];

  function automatic void empty_queue();
    lvl_map = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_is_free[i] = 1'b1;
      slot_level[i]   = small_first_q ? max_prio_q : 8'd0;
    end
    in_use = 0;
  endfunction

  // Best (or worst) level in use at or below the visible maximum.
  function automatic bit find_used(input bit lowest, output logic [LVL_W-1:0] lvl);
    int l;
    for (int i = 0; i <= max_prio_q; i++) begin
      l = lowest ? i : (max_prio_q - i);
      if (lvl_map[l]) begin
        lvl = LVL_W'(l);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit free_level(input logic [LVL_W-1:0] lvl,
                                    output logic [SLOT_W-1:0] s);
    if (in_use == 0 || lvl > max_prio_q || !lvl_map[lvl]) return 1'b0;
    s = level_slot[lvl];
    lvl_map[lvl] = 1'b0;
    slot_is_free[s] = 1'b1;
    in_use--;
    return 1'b1;
  endfunction

  // Applies one command to the behavioral queue and returns its result.
  function automatic res_t queue_response(input cmd_e cmd, input logic [LVL_W-1:0] pr,
                                          input logic [SLOT_W-1:0] nid);
    res_t r;
    logic [LVL_W-1:0] a, b;
    logic [SLOT_W-1:0] s;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        if (in_use < node_limit_q && pr <= max_prio_q) begin
          if (lvl_map[pr]) begin
            r.ok = 1'b1;
            r.node_out = level_slot[pr];
          end else begin
            for (int i = 0; i < node_limit_q; i++) begin
              if (slot_is_free[i]) begin
                slot_is_free[i] = 1'b0;
                slot_level[i] = pr;
                level_slot[pr] = SLOT_W'(i);
                lvl_map[pr] = 1'b1;
                in_use++;
                r.ok = 1'b1;
                r.node_out = SLOT_W'(i);
                break;
              end
            end
          end
        end
      end
      CMD_POP: begin
        if (find_used(small_first_q, a) && free_level(a, s)) begin
          r.ok = 1'b1;
          r.prio_out = a;
          r.node_out = s;
        end
      end
      CMD_RELEASE: begin
        if (free_level(pr, s)) begin
          r.ok = 1'b1;
          r.node_out = s;
        end
      end
      CMD_SCOPE: begin
        if (find_used(small_first_q, a) && find_used(!small_first_q, b)) begin
          r.ok = 1'b1;
          r.prio_out = a;
          r.worst_prio = b;
        end
      end
      CMD_PRIO_NODE: begin
        if (nid < node_limit_q) begin
          r.ok = 1'b1;
          r.prio_out = slot_level[nid];
        end
      end
      CMD_NODE_PRIO: begin
        if (pr <= max_prio_q && lvl_map[pr]) begin
          r.ok = 1'b1;
          r.node_out = level_slot[pr];
        end
      end
      CMD_STATUS: r.ok = 1'b1;
      default: begin
        empty_queue();
        r.ok = 1'b1;
      end
    endcase
    r.used_count = SLOT_W'(in_use);
    r.is_empty = (in_use == 0);
    return r;
  endfunction

  function automatic res_t mk_res(bit ok, int p, int w, int n, int cnt);
    res_t r;
    r.ok = ok;
    r.prio_out = LVL_W'(p);
    r.worst_prio = LVL_W'(w);
    r.node_out = SLOT_W'(n);
    r.used_count = SLOT_W'(cnt);
    r.is_empty = (cnt == 0);
    return r;
  endfunction

  function automatic void add_row(cmd_e c, int p, int n, bit typed, res_t want);
    row_t r;
    r.cmd = c;
    r.prio = LVL_W'(p);
    r.node = SLOT_W'(n);
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  // Offers one command, waits for its transaction and records the result.
  task automatic send_cmd(cmd_e c, logic [LVL_W-1:0] pr, logic [SLOT_W-1:0] nid,
                          bit typed, res_t want, bit no_gap);
    int gap;
    res_t got;
    gap = no_gap ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                   : $urandom_range(5, 30));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nid, pr, c};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = queue_response(c, pr, nid);
    pending_results.push_back(typed ? want : got);
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_PRIO:   max_prio_q = val;
      CFG_SMALL_HIGH: small_first_q = val[0];
      default:        node_limit_q = val[4:0];
    endcase
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (out_busy) begin
        g = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Result checking at each output transaction.
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.ok != want.ok) begin
          $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
          n_errors++;
        end
        if (got.prio_out != want.prio_out) begin
          $display("%0t: prio_out expected %0d actual %0d", $time,
                   want.prio_out, got.prio_out);
          n_errors++;
        end
        if (got.worst_prio != want.worst_prio) begin
          $display("%0t: worst_prio expected %0d actual %0d", $time,
                   want.worst_prio, got.worst_prio);
          n_errors++;
        end
        if (got.node_out != want.node_out) begin
          $display("%0t: node_out expected %0d actual %0d", $time,
                   want.node_out, got.node_out);
          n_errors++;
        end
        if (got.used_count != want.used_count) begin
          $display("%0t: used_count expected %0d actual %0d", $time,
                   want.used_count, got.used_count);
          n_errors++;
        end
        if (got.is_empty != want.is_empty) begin
          $display("%0t: is_empty expected %0d actual %0d", $time,
                   want.is_empty, got.is_empty);
          n_errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic [7:0] set_max [8] = '{8'd255, 8'd255, 8'd40, 8'd0, 8'd15, 8'd200, 8'd255, 8'd7};
    bit         set_ord [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    logic [4:0] set_lim [8] = '{5'd31, 5'd31, 5'd4, 5'd31, 5'd0, 5'd2, 5'd31, 5'd3};
    int   top;
    cmd_e c;
    logic [LVL_W-1:0] pr;
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    hold_req = 1'b0;
    out_busy = 1'b0;
    max_prio_q = 8'd255;
    small_first_q = 1'b1;
    node_limit_q = 5'd31;
    empty_queue();
    for (int i = 0; i < LEVELS; i++) level_slot[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under reset settings.
    add_row(CMD_STATUS, 0, 0, 1, mk_res(1, 0, 0, 0, 0));
    add_row(CMD_POP, 0, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(CMD_SCOPE, 0, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(CMD_RELEASE, 9, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(CMD_PRIO_NODE, 0, 5, 1, mk_res(1, 255, 0, 0, 0));
    add_row(CMD_PRIO_NODE, 0, 31, 1, mk_res(0, 0, 0, 0, 0));
    add_row(CMD_PUSH, 0, 0, 1, mk_res(1, 0, 0, 0, 1));
    add_row(CMD_PUSH, 255, 0, 1, mk_res(1, 0, 0, 1, 2));
    add_row(CMD_PUSH, 0, 0, 1, mk_res(1, 0, 0, 0, 2));
    add_row(CMD_SCOPE, 0, 0, 1, mk_res(1, 0, 255, 0, 2));
    add_row(CMD_NODE_PRIO, 255, 0, 1, mk_res(1, 0, 0, 1, 2));
    add_row(CMD_NODE_PRIO, 77, 0, 1, mk_res(0, 0, 0, 0, 2));
    add_row(CMD_PRIO_NODE, 0, 1, 1, mk_res(1, 255, 0, 0, 2));
    add_row(CMD_RELEASE, 7, 0, 1, mk_res(0, 0, 0, 0, 2));
    add_row(CMD_POP, 0, 0, 1, mk_res(1, 0, 0, 0, 1));
    add_row(CMD_PUSH, 128, 0, 0, '0);
    add_row(CMD_PUSH, 64, 0, 0, '0);
    add_row(CMD_RELEASE, 255, 0, 0, '0);
    add_row(CMD_POP, 0, 0, 0, '0);
    add_row(CMD_CLEAR, 0, 0, 1, mk_res(1, 0, 0, 0, 0));
    add_row(CMD_POP, 0, 0, 1, mk_res(0, 0, 0, 0, 0));
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].prio, rows[i].node,
                               rows[i].typed, rows[i].want, 1'b0);
    drain();

    // Random phases; queue contents carry over between settings, so entries
    // above a lowered maximum and slots above a lowered limit get exercised.
    out_busy = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_MAX_PRIO, set_max[ph]);
      write_reg(CFG_SMALL_HIGH, {7'd0, set_ord[ph]});
      write_reg(CFG_NODE_LIMIT, {3'd0, set_lim[ph]});
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < 160; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: c = CMD_PUSH;
          7, 8, 9:             c = CMD_POP;
          10, 11:              c = CMD_RELEASE;
          12, 13:              c = CMD_SCOPE;
          14, 15:              c = CMD_PRIO_NODE;
          16, 17:              c = CMD_NODE_PRIO;
          18:                  c = CMD_STATUS;
          default:             c = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_STATUS;
        endcase
        top = (set_max[ph] > 251) ? 255 : set_max[ph] + 4;
        pr = ($urandom_range(0, 7) == 0) ? LVL_W'($urandom) : LVL_W'($urandom_range(0, top));
        send_cmd(c, pr, SLOT_W'($urandom), 1'b0, '0, ph[0]);
      end
      drain();
    end
    while (hold_req) @(posedge clk_i);
    drain();

    $display("Sent %0d commands in a directed table and 8 random register settings;",
             n_sent);
    $display("%0d results compared, %0d field mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
